[rtl/atomic_block_remap_table_top_defines.svh]
// Assertion macros for the remap table block.
`ifndef ATOMIC_BLOCK_REMAP_TABLE_TOP_DEFINES_SVH
`define ATOMIC_BLOCK_REMAP_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/abrt_pkg.sv]
package abrt_pkg;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int MIN_BLOCKS = 2;
	localparam int BC_W = 7;
	localparam int FIELD_W = 6;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam logic [BC_W-1:0] DEFAULT_BLOCKS = 7'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_FORMAT  = 2'd0,
		CMD_COMMIT  = 2'd1,
		CMD_LOOKUP  = 2'd2,
		CMD_RECOVER = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_BAD_BLOCK     = 2'd1,
		ST_NOT_FORMATTED = 2'd2,
		ST_SEVERAL       = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FMT,
		S_ACCESS,
		S_CLR,
		S_MARK,
		S_DRAIN,
		S_SCAN,
		S_SDONE
	} state_t;

endpackage

[rtl/abrt_ram.sv]
module abrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/atomic_block_remap_table_top.sv]
// Remap table of logical to physical blocks, one command at a time; busy is high meanwhile.
// Lookup and commit read the table from idle, then answer from S_ACCESS, where commit also updates it.
// Rejected commands answer in the cycle after start. Format makes n-2 table writes, then sets the spare.
// Recover clears the marks, marks the blocks that the table and spare point at, then scans the marks.
// The done strobe lasts one cycle and cannot be stalled; the next start may come with it.
// Reset clears control state and the formatted flag; the table holds garbage until format.
module atomic_block_remap_table_top #(
	parameter int MAX_BLOCKS = abrt_pkg::MAX_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [abrt_pkg::BC_W-1:0]     cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [abrt_pkg::CMD_W-1:0]    cmd,
	input  logic [abrt_pkg::FIELD_W-1:0]  logical_block,
	output logic                          done,
	output logic [abrt_pkg::FIELD_W-1:0]  physical_block,
	output logic [abrt_pkg::FIELD_W-1:0]  spare_block,
	output logic [abrt_pkg::FIELD_W-1:0]  usable_blocks,
	output logic [abrt_pkg::STATUS_W-1:0] status
);

	import abrt_pkg::*;

	`include "atomic_block_remap_table_top_defines.svh"

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int NW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = ((NW > FIELD_W) ? NW : FIELD_W) + 1;

	logic [BC_W-1:0] block_count_q;
	logic [NW-1:0]   n;

	state_t  state_q, state_d;
	logic [NW-1:0] idx_q, idx_d;
	cmd_t    cmd_q;
	logic [AW-1:0] lb_q;
	logic [NW-1:0] n_q;
	logic [AW-1:0] spare_q, spare_d;
	logic    formatted_q, formatted_d;
	logic    vld_s1;
	logic [AW-1:0] idx_s1;
	logic [1:0] cnt_q, cnt_d;
	logic [AW-1:0] first_q, first_d;
	logic    accept;
	logic    rd_issue;

	logic    done_q, done_d;
	logic [FIELD_W-1:0] phys_q, phys_d;
	logic [FIELD_W-1:0] spare_out_q;
	logic [FIELD_W-1:0] usable_q;
	status_t status_q, status_d;
	logic [FIELD_W-1:0] res_phys;
	logic [NW-1:0] res_n;

	logic          tbl_we;
	logic [AW-1:0] tbl_waddr, tbl_wdata, tbl_raddr, tbl_rdata;
	logic          mk_we, mk_wdata, mk_rdata;
	logic [AW-1:0] mk_waddr, mk_raddr;
	logic [AW-1:0] p;
	logic          lb_ok;

	abrt_ram #(.WIDTH(AW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	abrt_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_marks (
		.clk   (clk),
		.we    (mk_we),
		.waddr (mk_waddr),
		.wdata (mk_wdata),
		.raddr (mk_raddr),
		.rdata (mk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= DEFAULT_BLOCKS;
		end else if (cfg_we) begin
			block_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (block_count_q < BC_W'(MIN_BLOCKS)) begin
			n = NW'(MIN_BLOCKS);
		end else if (int'(block_count_q) > MAX_BLOCKS) begin
			n = NW'(MAX_BLOCKS);
		end else begin
			n = NW'(block_count_q);
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign lb_ok  = (logical_block != '0) &&
		((CW'(logical_block) + CW'(2)) <= CW'(n));

	// Entry 0 lives in spare_q, so the mark pass takes it from there.
	assign p = (idx_s1 == '0) ? spare_q : tbl_rdata;

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		spare_d     = spare_q;
		formatted_d = formatted_q;
		cnt_d       = cnt_q;
		first_d     = first_q;
		tbl_we      = 1'b0;
		tbl_waddr   = idx_q[AW-1:0];
		tbl_wdata   = idx_q[AW-1:0];
		tbl_raddr   = idx_q[AW-1:0];
		mk_we       = 1'b0;
		mk_waddr    = idx_q[AW-1:0];
		mk_wdata    = 1'b0;
		mk_raddr    = idx_q[AW-1:0];
		rd_issue    = 1'b0;
		done_d      = 1'b0;
		res_phys    = '0;
		res_n       = n_q;
		status_d    = ST_OK;

		case (state_q)
			S_IDLE: begin
				res_n = n;
				cnt_d = '0;
				if (start) begin
					if (cmd_t'(cmd) == CMD_FORMAT) begin
						state_d = S_FMT;
						idx_d   = NW'(1);
					end else if (!formatted_q) begin
						done_d   = 1'b1;
						status_d = ST_NOT_FORMATTED;
					end else if (cmd_t'(cmd) == CMD_RECOVER) begin
						state_d = S_CLR;
						idx_d   = '0;
					end else if (!lb_ok) begin
						done_d   = 1'b1;
						status_d = ST_BAD_BLOCK;
					end else begin
						tbl_raddr = AW'(logical_block);
						state_d   = S_ACCESS;
					end
				end
			end
			S_FMT: begin
				if ((CW'(idx_q) + CW'(1)) < CW'(n_q)) begin
					tbl_we = 1'b1;
					idx_d  = idx_q + NW'(1);
				end else begin
					spare_d     = AW'(n_q - NW'(1));
					formatted_d = 1'b1;
					done_d      = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_ACCESS: begin
				if (cmd_q == CMD_COMMIT) begin
					tbl_we    = 1'b1;
					tbl_waddr = lb_q;
					tbl_wdata = spare_q;
					spare_d   = tbl_rdata;
					res_phys  = FIELD_W'(spare_q);
				end else begin
					res_phys = FIELD_W'(tbl_rdata);
				end
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_CLR: begin
				mk_we = 1'b1;
				if (idx_q == n_q - NW'(1)) begin
					state_d = S_MARK;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + NW'(1);
				end
			end
			S_MARK, S_DRAIN: begin
				if (vld_s1 && (NW'(p) < n_q)) begin
					mk_we    = 1'b1;
					mk_waddr = p;
					mk_wdata = 1'b1;
				end
				if (state_q == S_MARK) begin
					rd_issue = 1'b1;
					if ((CW'(idx_q) + CW'(2)) == CW'(n_q)) begin
						state_d = S_DRAIN;
					end else begin
						idx_d = idx_q + NW'(1);
					end
				end else begin
					state_d = S_SCAN;
					idx_d   = NW'(1);
				end
			end
			S_SCAN, S_SDONE: begin
				if (vld_s1 && !mk_rdata) begin
					if (cnt_q == 2'd0) begin
						first_d = idx_s1;
					end
					if (cnt_q != 2'd2) begin
						cnt_d = cnt_q + 2'd1;
					end
				end
				if (state_q == S_SCAN) begin
					rd_issue = 1'b1;
					if (idx_q == n_q - NW'(1)) begin
						state_d = S_SDONE;
					end else begin
						idx_d = idx_q + NW'(1);
					end
				end else begin
					if (cnt_d != 2'd0) begin
						spare_d = first_d;
					end
					status_d = (cnt_d > 2'd1) ? ST_SEVERAL : ST_OK;
					done_d   = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		phys_d = res_phys;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			spare_q     <= '0;
			formatted_q <= 1'b0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			spare_q     <= spare_d;
			formatted_q <= formatted_d;
			cnt_q       <= cnt_d;
			vld_s1      <= rd_issue;
			done_q      <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			lb_q  <= AW'(logical_block);
			n_q   <= n;
		end
		idx_s1  <= idx_q[AW-1:0];
		first_q <= first_d;
		if (done_d) begin
			phys_q      <= phys_d;
			spare_out_q <= FIELD_W'(spare_d);
			usable_q    <= FIELD_W'(res_n - NW'(2));
			status_q    <= status_d;
		end
	end

	assign done           = done_q;
	assign physical_block = phys_q;
	assign spare_block    = spare_out_q;
	assign usable_blocks  = usable_q;
	assign status         = status_q;

	`ABRT_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result strobe while busy")
	`ABRT_ASSERT_NEXT(a_access_one, state_q == S_ACCESS, done_q && state_q == S_IDLE, "access did not finish")
	`ABRT_ASSERT_NOW(a_mark_we, mk_we, state_q == S_CLR || state_q == S_MARK || state_q == S_DRAIN, "mark write outside recover")
	`ABRT_ASSERT_NOW(a_tbl_we, tbl_we, state_q == S_FMT || (state_q == S_ACCESS && cmd_q == CMD_COMMIT), "stray table write")
	`ABRT_ASSERT_NOW(a_several, done_q && status_q == ST_SEVERAL, $past(state_q) == S_SDONE, "several unmapped without scan")

endmodule
